>>> hw/rtl/sec_pkg.sv
// shared types and codes of the sparse embedding combine unit
`default_nettype none
package sec_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR_OUT,
    ST_ACC_SQ,
    ST_ACC_SQADD,
    ST_ACC_RD,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_EM_START,
    ST_EM_SQRT,
    ST_EM_CHK,
    ST_EM_DIV0,
    ST_EM_DIV,
    ST_EM_OUT,
    ST_EM_DONE
  } sec_state_e;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_LEN  = 2'd2;

  // combine modes
  localparam logic [1:0] MODE_SUM   = 2'd0;
  localparam logic [1:0] MODE_MEAN  = 2'd1;
  localparam logic [1:0] MODE_SQRTN = 2'd2;

  // request types
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_ROW  = 2'd1;
  localparam logic [1:0] STAT_ZERO_DIV = 2'd2;

  localparam int DIV_STEPS = 49;

endpackage
`default_nettype wire

>>> hw/rtl/sec_if.sv
// request and result channel interfaces
`default_nettype none
interface sec_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [15:0]        row_id;
  logic [3:0]         column;
  logic signed [15:0] element_value;
  logic [15:0]        bucket;
  logic signed [15:0] weight;
  logic               end_of_batch;

  modport source (output valid, req_type, row_id, column, element_value, bucket, weight,
                  end_of_batch, input ready);
  modport sink (input valid, req_type, row_id, column, element_value, bucket, weight,
                end_of_batch, output ready);
endinterface

interface sec_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_bucket;
  logic [3:0]         element_index;
  logic signed [31:0] value;
  logic               last;
  logic [1:0]         status;

  modport source (output valid, out_bucket, element_index, value, last, status,
                  input ready);
  modport sink (input valid, out_bucket, element_index, value, last, status,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sparse_embedding_combine_unit.sv
// weighted embedding-bag combiner: table store, accumulators, sequencer and shared divider
// table write: taken as the request is accepted. lookup: square of the weight, then a read, multiply
// and add per element, with one shared multiplier. emission of a bucket: L elements through the
// bit-serial divider (skipped for a zero divisor), after a square root in sqrtn mode; one transaction at a time
// reset clears control and accumulators and sets config registers to defaults; table contents stay undefined
`default_nettype none
module sparse_embedding_combine_unit import sec_pkg::*; #(
  parameter int TABLE_ROWS = 256,
  parameter int EMBED_DIM  = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  sec_in_if.sink          in_i,
  sec_out_if.source       out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i
);

  localparam int LCAP  = (EMBED_DIM < 16) ? EMBED_DIM : 16;
  localparam int IW    = (LCAP > 1) ? $clog2(LCAP) : 1;
  localparam int RW    = $clog2(TABLE_ROWS);
  localparam int DEPTH = TABLE_ROWS * EMBED_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [1:0] mode_q;
  logic [8:0] row_count_q;
  logic [4:0] embed_len_q;

  // sequencer and latched request
  sec_state_e         state_q, state_d;
  logic [RW-1:0]      row_q;
  logic [15:0]        bkt_q;
  logic signed [15:0] w_q;
  logic               eob_q;
  logic               pend_q;
  logic [IW-1:0]      idx_q;

  // bucket state
  logic signed [47:0] accum_q [LCAP];
  logic signed [31:0] wsum_q;
  logic [47:0]        sqsum_q;
  logic [15:0]        open_id_q;
  logic               open_q;

  // table memory
  logic [15:0]        mem [DEPTH];
  logic signed [15:0] rd_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;

  // shared arithmetic
  logic signed [31:0] prod_q;
  logic signed [15:0] mul_a;
  logic signed [47:0] div_q;
  logic [47:0]        ud_q;
  logic               dneg_q, neg_q, zdiv_q;
  logic [48:0]        num_q;
  logic [47:0]        rem_q;
  logic [5:0]         cnt_q;
  logic signed [31:0] val_q;
  logic [47:0]        sv_q, sr_q, sb_q;

  // output register
  logic               out_valid_q;
  logic [15:0]        o_bkt_q;
  logic [3:0]         o_idx_q;
  logic signed [31:0] o_val_q;
  logic               o_last_q;
  logic [1:0]         o_stat_q;

  logic          in_ready, in_acc, row_ok, slot_free, idx_last;
  logic [4:0]    eff_len;
  logic [IW-1:0] lenm1;

  assign in_acc    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign row_ok    = ({1'b0, in_i.row_id} < 17'(TABLE_ROWS)) &&
                     (in_i.row_id < {7'd0, row_count_q});

  // effective length: zero counts as one, capped at the row width and at 16
  always_comb begin
    eff_len = (embed_len_q == 5'd0) ? 5'd1 : embed_len_q;
    if (32'(eff_len) > LCAP) eff_len = 5'(LCAP);
    lenm1 = IW'(eff_len - 5'd1);
  end
  assign idx_last = (idx_q == lenm1);

  assign rd_addr = AW'(32'(row_q) * EMBED_DIM + 32'(idx_q));
  assign wr_addr = AW'(32'(in_i.row_id[RW-1:0]) * EMBED_DIM + 32'(in_i.column));
  assign wr_en   = in_acc && (in_i.req_type == REQ_WRITE) && row_ok &&
                   (32'(in_i.column) < EMBED_DIM);

  // next state
  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid && in_i.req_type == REQ_LOOKUP) begin
          if (!row_ok) state_d = ST_ERR_OUT;
          else if (open_q && in_i.bucket != open_id_q) state_d = ST_EM_START;
          else state_d = ST_ACC_SQ;
        end
      end
      ST_ERR_OUT: if (slot_free) state_d = (eob_q && open_q) ? ST_EM_START : ST_IDLE;
      ST_ACC_SQ:    state_d = ST_ACC_SQADD;
      ST_ACC_SQADD: state_d = ST_ACC_MUL;
      ST_ACC_RD:    state_d = ST_ACC_MUL;
      ST_ACC_MUL:   state_d = ST_ACC_ADD;
      ST_ACC_ADD: begin
        if (idx_last) state_d = eob_q ? ST_EM_START : ST_IDLE;
        else state_d = ST_ACC_RD;
      end
      ST_EM_START:  state_d = (mode_q == MODE_SQRTN) ? ST_EM_SQRT : ST_EM_CHK;
      ST_EM_SQRT:   if (sb_q == 48'd1) state_d = ST_EM_CHK;
      ST_EM_CHK:    state_d = (div_q == 48'sd0) ? ST_EM_OUT : ST_EM_DIV0;
      ST_EM_DIV0:   state_d = ST_EM_DIV;
      ST_EM_DIV:    if (cnt_q == 6'd1) state_d = ST_EM_OUT;
      ST_EM_OUT: begin
        if (slot_free) begin
          if (idx_last) state_d = ST_EM_DONE;
          else state_d = zdiv_q ? ST_EM_OUT : ST_EM_DIV0;
        end
      end
      ST_EM_DONE:   state_d = pend_q ? ST_ACC_SQ : ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // arithmetic helpers
  logic signed [32:0] wsum_x;
  logic [48:0]        sq_x;
  logic signed [48:0] acc_x;
  logic signed [47:0] acc_sel;
  logic [47:0]        ua, sq_t, sr_nx;
  logic [48:0]        rem_sh;
  logic               ge;
  logic [48:0]        q_nx;
  logic signed [31:0] q_sat;

  assign mul_a   = (state_q == ST_ACC_SQ) ? w_q : rd_q;
  assign wsum_x  = 33'(wsum_q) + 33'(w_q);
  assign sq_x    = {1'b0, sqsum_q} + {17'd0, prod_q};
  assign acc_sel = accum_q[idx_q];
  assign acc_x   = 49'(acc_sel) + 49'(prod_q);
  assign ua      = acc_sel[47] ? 48'(-acc_sel) : 48'(acc_sel);
  assign sq_t    = sr_q + sb_q;
  assign sr_nx   = (sv_q >= sq_t) ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
  assign rem_sh  = {rem_q, num_q[48]};
  assign ge      = rem_sh >= {1'b0, ud_q};
  assign q_nx    = {num_q[47:0], ge};

  // quotient saturation to 32 bits signed
  always_comb begin
    if (neg_q) q_sat = (q_nx > 49'h0_8000_0000) ? 32'sh8000_0000 : -$signed(q_nx[31:0]);
    else q_sat = (q_nx > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_nx[31:0]);
  end

  // control, bucket state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_SUM;
      row_count_q <= 9'd256;
      embed_len_q <= 5'd16;
      for (int i = 0; i < LCAP; i++) accum_q[i] <= '0;
      wsum_q      <= '0;
      sqsum_q     <= '0;
      open_id_q   <= '0;
      open_q      <= 1'b0;
      pend_q      <= 1'b0;
      eob_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE: mode_q      <= cfg_data_i[1:0];
          CFG_ROWS: row_count_q <= cfg_data_i;
          CFG_LEN:  embed_len_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_acc && in_i.req_type == REQ_LOOKUP) begin
        eob_q  <= in_i.end_of_batch;
        pend_q <= row_ok;
      end
      case (state_q)
        ST_ACC_SQ: begin
          pend_q <= 1'b0;
          idx_q  <= '0;
          if (wsum_x[32] != wsum_x[31]) wsum_q <= wsum_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          else wsum_q <= wsum_x[31:0];
        end
        ST_ACC_SQADD: sqsum_q <= sq_x[48] ? '1 : sq_x[47:0];
        ST_ACC_ADD: begin
          if (acc_x[48] != acc_x[47])
            accum_q[idx_q] <= acc_x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          else accum_q[idx_q] <= acc_x[47:0];
          if (idx_last) begin
            open_q    <= 1'b1;
            open_id_q <= bkt_q;
          end else idx_q <= idx_q + 1'b1;
        end
        ST_EM_CHK: idx_q <= '0;
        ST_EM_OUT: if (slot_free && !idx_last) idx_q <= idx_q + 1'b1;
        ST_EM_DONE: begin
          for (int i = 0; i < LCAP; i++) accum_q[i] <= '0;
          wsum_q  <= '0;
          sqsum_q <= '0;
          open_q  <= 1'b0;
        end
        default: ;
      endcase
      if ((state_q == ST_ERR_OUT || state_q == ST_EM_OUT) && slot_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= in_i.element_value;
    rd_q <= $signed(mem[rd_addr]);
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q <= in_i.row_id[RW-1:0];
      bkt_q <= in_i.bucket;
      w_q   <= in_i.weight;
    end
    if (state_q == ST_ACC_SQ || state_q == ST_ACC_MUL) prod_q <= mul_a * w_q;
    case (state_q)
      ST_EM_START: begin
        if (mode_q == MODE_MEAN) div_q <= 48'(wsum_q);
        else div_q <= 48'sd4096;
        sv_q <= sqsum_q;
        sr_q <= '0;
        sb_q <= 48'd1 << 46;
      end
      ST_EM_SQRT: begin
        if (sv_q >= sq_t) sv_q <= sv_q - sq_t;
        sr_q <= sr_nx;
        sb_q <= sb_q >> 2;
        if (sb_q == 48'd1) div_q <= $signed(sr_nx);
      end
      ST_EM_CHK: begin
        zdiv_q <= (div_q == 48'sd0);
        dneg_q <= div_q[47];
        ud_q   <= div_q[47] ? 48'(-div_q) : 48'(div_q);
      end
      ST_EM_DIV0: begin
        num_q <= {1'b0, ua} + {2'b0, ud_q[47:1]};
        rem_q <= '0;
        cnt_q <= 6'(DIV_STEPS);
        neg_q <= acc_sel[47] ^ dneg_q;
      end
      ST_EM_DIV: begin
        rem_q <= ge ? 48'(rem_sh - {1'b0, ud_q}) : rem_sh[47:0];
        num_q <= q_nx;
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) val_q <= q_sat;
      end
      default: ;
    endcase
    if (state_q == ST_ERR_OUT && slot_free) begin
      o_bkt_q  <= bkt_q;
      o_idx_q  <= '0;
      o_val_q  <= '0;
      o_last_q <= 1'b1;
      o_stat_q <= STAT_BAD_ROW;
    end else if (state_q == ST_EM_OUT && slot_free) begin
      o_bkt_q  <= open_id_q;
      o_idx_q  <= 4'(idx_q);
      o_val_q  <= zdiv_q ? 32'sd0 : val_q;
      o_last_q <= idx_last;
      o_stat_q <= zdiv_q ? STAT_ZERO_DIV : STAT_OK;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_bucket    = o_bkt_q;
  assign out_o.element_index = o_idx_q;
  assign out_o.value         = o_val_q;
  assign out_o.last          = o_last_q;
  assign out_o.status        = o_stat_q;

endmodule
`default_nettype wire

>>> tb/sec_checker.sv
// result checker: watches both channels, predicts the combined vectors and compares
`default_nettype none
module sec_checker import sec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  sec_in_if               in_i,
  sec_out_if              out_i,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint unsigned SQ_HI = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct {
    logic [15:0]        bkt;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               last;
    logic [1:0]         st;
  } combined_elem_t;

  combined_elem_t    combined_q[$];
  logic [15:0]       table_mem [0:4095];
  longint            acc_vec [16];
  longint            wt_sum;
  longint unsigned   sq_sum;
  bit                bkt_open;
  logic [15:0]       bkt_id;
  logic [1:0]        mode;
  logic [8:0]        rows;
  logic [4:0]        vec_len;
  int                fails;

  assign fail_count_o = fails;
  assign pending_o    = combined_q.size();

  function automatic int unsigned used_len();
    int unsigned l;
    l = (vec_len == 0) ? 1 : vec_len;
    return (l > 16) ? 16 : l;
  endfunction

  function automatic int unsigned row_limit();
    return (rows < 256) ? rows : 256;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // round half away from zero, saturate to 32 bits
  function automatic logic signed [31:0] round_div(longint a, longint d);
    bit              neg;
    longint unsigned ua, ud, q;
    neg = (a < 0) != (d < 0);
    ua  = (a < 0) ? -a : a;
    ud  = (d < 0) ? -d : d;
    q   = (ua + ud / 2) / ud;
    if (neg) return (q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
  endfunction

  task automatic emit_bucket();
    longint         d;
    int unsigned    n;
    combined_elem_t e;
    n = used_len();
    d = 4096;
    if (mode == MODE_MEAN) d = wt_sum;
    else if (mode == MODE_SQRTN) d = int_sqrt(sq_sum);
    for (int i = 0; i < n; i++) begin
      e.bkt  = bkt_id;
      e.idx  = 4'(i);
      e.st   = (d == 0) ? STAT_ZERO_DIV : STAT_OK;
      e.val  = (d == 0) ? 32'sd0 : round_div(acc_vec[i], d);
      e.last = (i + 1 == n);
      combined_q.push_back(e);
    end
    foreach (acc_vec[i]) acc_vec[i] = 0;
    wt_sum   = 0;
    sq_sum   = 0;
    bkt_open = 0;
  endtask

  task automatic take_request();
    longint         w, s, a;
    longint unsigned sq;
    combined_elem_t e;
    if (in_i.req_type == REQ_WRITE) begin
      // bad writes are dropped silently
      if (in_i.row_id < row_limit())
        table_mem[{in_i.row_id[7:0], in_i.column}] = in_i.element_value;
      return;
    end
    if (in_i.row_id >= row_limit()) begin
      e.bkt = in_i.bucket; e.idx = 0; e.val = 0; e.last = 1'b1; e.st = STAT_BAD_ROW;
      combined_q.push_back(e);
    end else begin
      w = in_i.weight;
      if (bkt_open && in_i.bucket != bkt_id) emit_bucket();
      bkt_open = 1;
      bkt_id   = in_i.bucket;
      s = wt_sum + w;
      wt_sum = (s > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : (s < -64'sh8000_0000) ? -64'sh8000_0000 : s;
      sq = sq_sum + longint'(w * w);
      sq_sum = (sq > SQ_HI) ? SQ_HI : sq;
      for (int i = 0; i < used_len(); i++) begin
        a = acc_vec[i] + longint'($signed(table_mem[{in_i.row_id[7:0], 4'(i)}])) * w;
        acc_vec[i] = (a > ACC_HI) ? ACC_HI : (a < ACC_LO) ? ACC_LO : a;
      end
    end
    if (in_i.end_of_batch && bkt_open) emit_bucket();
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t: result mismatch on %s: got %0d, wanted %0d", $realtime, what, got, want);
    fails++;
  endtask

  task automatic check_result();
    combined_elem_t e;
    if (combined_q.size() == 0) begin
      report("unexpected transaction, bucket", out_i.out_bucket, -1);
      return;
    end
    e = combined_q.pop_front();
    if (out_i.out_bucket !== e.bkt) report("out_bucket", out_i.out_bucket, e.bkt);
    if (out_i.element_index !== e.idx) report("element_index", out_i.element_index, e.idx);
    if (out_i.value !== e.val) report("value", out_i.value, e.val);
    if (out_i.last !== e.last) report("last", out_i.last, e.last);
    if (out_i.status !== e.st) report("status", out_i.status, e.st);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combined_q.delete();
      foreach (acc_vec[i]) acc_vec[i] = 0;
      wt_sum   = 0;
      sq_sum   = 0;
      bkt_open = 0;
      bkt_id   = '0;
      mode     = MODE_SUM;
      rows     = 9'd256;
      vec_len  = 5'd16;
      fails    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE: mode    = cfg_data_i[1:0];
          CFG_ROWS: rows    = cfg_data_i;
          CFG_LEN:  vec_len = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) take_request();
      if (out_i.valid && out_i.ready) check_result();
    end
  end
endmodule
`default_nettype wire

>>> tb/tb_sparse_embedding_combine_unit.sv
// top of the testbench: clock, reset, stimulus, watchdog and verdict
`default_nettype none
module tb_sparse_embedding_combine_unit import sec_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 8000;  // idle cycles without any transaction
  localparam int SETTLE      = 150;   // longest lookup walk plus margin

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_MODE;
  logic [8:0] cfg_data = '0;
  int         fail_count, pending;
  bit         idle_en = 1'b1;
  int         quiet_cycles = 0;

  // rows whose whole vector has been loaded; only these are ever looked up in range
  logic [7:0]  loaded_rows[$];
  logic [8:0]  cur_rows = 9'd256;
  logic [15:0] cur_bucket = '0;

  sec_in_if  req_ch ();
  sec_out_if res_ch ();

  sparse_embedding_combine_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  sec_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (req_ch),
    .out_i        (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result sink: random stall bursts mixed with open stretches
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end else begin
        res_ch.ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  // one request transaction; called at a falling edge, returns at a falling edge
  task automatic send(logic rt, logic [15:0] row, logic [3:0] col, logic [15:0] ev,
                      logic [15:0] bkt, logic [15:0] w, logic eob);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    req_ch.req_type      = rt;
    req_ch.row_id        = row;
    req_ch.column        = col;
    req_ch.element_value = ev;
    req_ch.bucket        = bkt;
    req_ch.weight        = w;
    req_ch.end_of_batch  = eob;
    req_ch.valid         = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic lookup(logic [15:0] row, logic [15:0] bkt, logic [15:0] w, logic eob);
    send(REQ_LOOKUP, row, $urandom, $urandom, bkt, w, eob);
  endtask

  // register writes only happen once every result has drained and the walk is over
  task automatic set_regs(logic [1:0] m, logic [8:0] r, logic [4:0] l);
    req_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = CFG_MODE; cfg_data = {7'd0, m};
    @(negedge clk_i);
    cfg_idx = CFG_ROWS; cfg_data = r;
    @(negedge clk_i);
    cfg_idx = CFG_LEN;  cfg_data = {4'd0, l};
    @(negedge clk_i);
    cfg_we = 1'b0;
    cur_rows = r;
  endtask

  function automatic logic [8:0] pick_rows();
    case ($urandom_range(0, 5))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd511;
      3: return $urandom_range(2, 255);
      default: return 9'd256;
    endcase
  endfunction

  function automatic logic [4:0] pick_len();
    case ($urandom_range(0, 4))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd31;
      3: return 5'd16;
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  // mostly sorted runs of lookups into one bucket, with writes and bad ids as noise
  task automatic random_item();
    int unsigned sel;
    logic [15:0] w;
    sel = $urandom_range(0, 99);
    w = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 255) - 128) : 16'($urandom);
    if ($urandom_range(0, 3) == 0) cur_bucket = cur_bucket + $urandom_range(1, 4000);
    if (sel < 10) begin
      // table rewrite of a loaded row, or a write that must be dropped
      if ($urandom_range(0, 1) == 0)
        send(REQ_WRITE, loaded_rows[$urandom_range(0, loaded_rows.size() - 1)],
             $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send(REQ_WRITE, $urandom_range(256, 65535), $urandom, $urandom, $urandom,
             $urandom, $urandom);
    end else if (sel < 20) begin
      lookup($urandom_range(cur_rows < 256 ? cur_rows : 256, 65535), $urandom, w,
             $urandom_range(0, 3) == 0);
    end else begin
      lookup(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)], cur_bucket, w,
             $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    logic [7:0] r;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_WRITE;
    req_ch.row_id = '0;
    req_ch.column = '0;
    req_ch.element_value = '0;
    req_ch.bucket = '0;
    req_ch.weight = '0;
    req_ch.end_of_batch = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // table load: row 0 at the negative extreme, row 255 at the positive one
    loaded_rows = '{8'd0, 8'd255, 8'd1, 8'd2};
    repeat (4) begin
      do r = $urandom; while (r inside {loaded_rows});
      loaded_rows.push_back(r);
    end
    foreach (loaded_rows[i])
      for (int c = 0; c < 16; c++)
        send(REQ_WRITE, loaded_rows[i], c,
             (i == 0) ? 16'h8000 : (i == 1) ? 16'h7FFF : 16'($urandom), $urandom,
             $urandom, 1'b0);

    // directed: sum of the extremes, bad id at the top of the range
    set_regs(MODE_SUM, 9'd256, 5'd16);
    lookup(16'd255, 16'd0, 16'h7FFF, 1'b0);
    lookup(16'd0, 16'd0, 16'h8000, 1'b1);
    lookup(16'hFFFF, 16'hFFFF, 16'h1000, 1'b1);
    lookup(16'd1, 16'hFFFF, 16'h1000, 1'b0);
    lookup(16'd2, 16'h0001, 16'h0800, 1'b1);
    // mean: weights that cancel give a zero divisor, near-cancelling ones a divisor of one
    set_regs(MODE_MEAN, 9'd256, 5'd16);
    lookup(16'd1, 16'd10, 16'h1000, 1'b0);
    lookup(16'd2, 16'd10, -16'sh1000, 1'b1);
    lookup(16'd255, 16'd11, 16'h7FFF, 1'b0);
    lookup(16'd0, 16'd11, 16'h8002, 1'b1);
    // root of squares: zero weight only, then ordinary runs
    set_regs(MODE_SQRTN, 9'd256, 5'd1);
    lookup(16'd1, 16'd20, 16'h0000, 1'b1);
    lookup(16'd255, 16'd21, 16'h7FFF, 1'b0);
    lookup(16'd1, 16'd21, 16'h0400, 1'b1);
    // unused mode acts as sum; too few rows makes loaded rows out of range
    set_regs(2'd3, 9'd2, 5'd0);
    lookup(16'd1, 16'd30, 16'h1000, 1'b0);
    lookup(16'd255, 16'd31, 16'h1000, 1'b1);
    send(REQ_WRITE, 16'd255, 4'd15, 16'h1234, 16'd0, 16'd0, 1'b1);
    lookup(16'd0, 16'd32, 16'h1000, 1'b1);
    // length change while a bucket stays open
    set_regs(MODE_SUM, 9'd511, 5'd4);
    lookup(16'd1, 16'd40, 16'h1000, 1'b0);
    set_regs(MODE_SUM, 9'd511, 5'd31);
    lookup(16'd2, 16'd40, 16'h1000, 1'b1);

    // random phases over varied settings, the last one without idling
    for (int p = 0; p < 11; p++) begin
      if (p == 10) begin
        idle_en = 1'b0;
        set_regs(MODE_SQRTN, 9'd256, 5'd16);
      end else begin
        set_regs($urandom_range(0, 3), pick_rows(), pick_len());
      end
      repeat (17) random_item();
    end

    req_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/sec_pkg.sv
hw/rtl/sec_if.sv
hw/rtl/sparse_embedding_combine_unit.sv
tb/sec_checker.sv
tb/tb_sparse_embedding_combine_unit.sv
